FILE: rtl/core/sbst_pkg.sv
`default_nettype none

package sbst_pkg;

   // coordinate width of the Q16.8 inputs
   localparam int COORD_BITS = 24;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   // doubled-coordinate slab numerators and denominators
   localparam int NUM_BITS   = COORD_BITS + 3;
   localparam int DEN_BITS   = COORD_BITS + 2;
   localparam int PROD_BITS  = NUM_BITS + DEN_BITS;

   localparam int AXES       = 3;
   // ordered pairs of distinct axes (entry axis, exit axis)
   localparam int NUM_PAIRS  = AXES * (AXES - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SIZE_BITS-1:0]  size_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   // one axis after the front end: entry/exit parameter as n/den, den > 0 when active
   typedef struct packed {
      logic signed [NUM_BITS-1:0] n_entry;
      logic signed [NUM_BITS-1:0] n_exit;
      logic signed [DEN_BITS-1:0] den;
      logic                       active;  // direction nonzero
      logic                       fail;    // start outside slab (used for zero direction only)
   } axis_type;

endpackage

`default_nettype wire

FILE: rtl/core/sbst_if.sv
`default_nettype none

interface sbst_req_if;
   import sbst_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;
   coord_type box_center_x;
   coord_type box_center_y;
   coord_type box_center_z;
   size_type  box_size_x;
   size_type  box_size_y;
   size_type  box_size_z;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z,
             box_center_x, box_center_y, box_center_z,
             box_size_x, box_size_y, box_size_z,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
             box_center_x, box_center_y, box_center_z,
             box_size_x, box_size_y, box_size_z,
      output ready
   );
endinterface

interface sbst_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sbst_axis_prep.sv
`default_nettype none

module sbst_axis_prep (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire sbst_pkg::coord_type start_c,
   input  wire sbst_pkg::coord_type end_c,
   input  wire sbst_pkg::coord_type center_c,
   input  wire sbst_pkg::size_type  size_c,
   output sbst_pkg::axis_type       axis_ff
);
   import sbst_pkg::*;

   logic signed [COORD_BITS:0]   diff;
   logic signed [NUM_BITS-1:0]   pos2;
   logic signed [NUM_BITS-1:0]   ctr2;
   logic signed [NUM_BITS-1:0]   size_ext;
   logic signed [NUM_BITS-1:0]   bmin;
   logic signed [NUM_BITS-1:0]   bmax;
   logic signed [DEN_BITS-1:0]   dbl;
   axis_type                     axis_in;

   always_comb begin
      diff     = {end_c[COORD_BITS-1], end_c} - {start_c[COORD_BITS-1], start_c};
      pos2     = {{2{start_c[COORD_BITS-1]}}, start_c, 1'b0};
      ctr2     = {{2{center_c[COORD_BITS-1]}}, center_c, 1'b0};
      size_ext = {4'b0000, size_c};
      bmin     = ctr2 - size_ext;
      bmax     = ctr2 + size_ext;
      dbl      = {diff, 1'b0};

      axis_in.active = (diff != '0);
      axis_in.fail   = (pos2 < bmin) || (pos2 > bmax);
      if (!diff[COORD_BITS]) begin
         axis_in.n_entry = bmin - pos2;
         axis_in.n_exit  = bmax - pos2;
         axis_in.den     = dbl;
      end else begin
         axis_in.n_entry = pos2 - bmax;
         axis_in.n_exit  = pos2 - bmin;
         axis_in.den     = -dbl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         axis_ff <= axis_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sbst_pair_mul.sv
`default_nettype none

// Cross products for entry(lower axis) <= exit(upper axis):
//   n_entry_l * den_u  vs  n_exit_u * den_l
module sbst_pair_mul (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire sbst_pkg::axis_type lower_axis,
   input  wire sbst_pkg::axis_type upper_axis,
   output sbst_pkg::prod_type      lhs_ff,
   output sbst_pkg::prod_type      rhs_ff
);
   import sbst_pkg::*;

   logic signed [NUM_BITS-1:0] ne_lo;
   logic signed [NUM_BITS-1:0] nx_up;
   logic signed [DEN_BITS-1:0] den_lo;
   logic signed [DEN_BITS-1:0] den_up;
   prod_type                   lhs_in;
   prod_type                   rhs_in;

   always_comb begin
      ne_lo  = lower_axis.n_entry;
      nx_up  = upper_axis.n_exit;
      den_lo = lower_axis.den;
      den_up = upper_axis.den;
      lhs_in = ne_lo * den_up;
      rhs_in = nx_up * den_lo;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/segment_box_slab_test.sv
// Segment versus axis-aligned box slab test, three register stages.
// An accepted req word reaches its rsp word through the stage 1, 2 and 3 registers.
// Throughput: one word per cycle; the three-stage pipe with per-stage valid
//   bits holds up to three words, and a stall on rsp backs up stage by stage.
// Reset (synchronous, active high) clears the stage valid bits only; the
//   datapath registers are not reset.
`default_nettype none

module segment_box_slab_test (
   input  wire logic  clock,
   input  wire logic  reset,
   sbst_req_if.sink   req_bus,
   sbst_rsp_if.source rsp_bus
);
   import sbst_pkg::*;

   // ------------------------------------------------------------------
   // Pipe control: a stage takes a new word (or bubble) when it is empty
   // or the stage after it moves this cycle.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   assign rdy3 = !v3_ff || rsp_bus.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_bus.ready = rdy1;

   assign v1_in = rdy1 ? req_bus.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff         : v2_ff;
   assign v3_in = rdy3 ? v2_ff         : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: per-axis front end. Works in doubled coordinates so the
   // bounds center -/+ size/2 are exact. Each moving axis yields its
   // entry and exit parameters as n/den with den > 0.
   // ------------------------------------------------------------------
   axis_type axis1 [AXES];

   sbst_axis_prep u_prep_x (
      .clock    (clock),
      .load     (rdy1),
      .start_c  (req_bus.start_x),
      .end_c    (req_bus.end_x),
      .center_c (req_bus.box_center_x),
      .size_c   (req_bus.box_size_x),
      .axis_ff  (axis1[0])
   );

   sbst_axis_prep u_prep_y (
      .clock    (clock),
      .load     (rdy1),
      .start_c  (req_bus.start_y),
      .end_c    (req_bus.end_y),
      .center_c (req_bus.box_center_y),
      .size_c   (req_bus.box_size_y),
      .axis_ff  (axis1[1])
   );

   sbst_axis_prep u_prep_z (
      .clock    (clock),
      .load     (rdy1),
      .start_c  (req_bus.start_z),
      .end_c    (req_bus.end_z),
      .center_c (req_bus.box_center_z),
      .size_c   (req_bus.box_size_z),
      .axis_ff  (axis1[2])
   );

   // ------------------------------------------------------------------
   // Stage 2: the clipped interval [max entry, min exit] is nonempty iff
   // every entry candidate is <= every exit candidate. Candidates are 0,
   // 1 and the moving axes' parameters. Same-axis pairs always hold
   // (size >= 0); cross-axis pairs need the cross products below.
   // Per axis: entry <= 1, exit >= 0, or for a still axis the start
   // must lie inside the slab.
   // ------------------------------------------------------------------
   prod_type lhs2 [NUM_PAIRS];
   prod_type rhs2 [NUM_PAIRS];
   logic [AXES-1:0] axis_ok_ff, axis_ok_in;
   logic [AXES-1:0] act2_ff, act2_in;

   for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
      localparam int LO = k / 2;
      localparam int HI = (k / 2 + 1 + k % 2) % AXES;

      sbst_pair_mul u_mul (
         .clock      (clock),
         .load       (rdy2),
         .lower_axis (axis1[LO]),
         .upper_axis (axis1[HI]),
         .lhs_ff     (lhs2[k]),
         .rhs_ff     (rhs2[k])
      );
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         act2_in[a] = axis1[a].active;
         if (axis1[a].active) begin
            axis_ok_in[a] = (axis1[a].n_entry <= axis1[a].den) && !axis1[a].n_exit[NUM_BITS-1];
         end else begin
            axis_ok_in[a] = !axis1[a].fail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         axis_ok_ff <= axis_ok_in;
         act2_ff    <= act2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: compare cross products, reduce to the hit flag.
   // ------------------------------------------------------------------
   logic [NUM_PAIRS-1:0] pair_ok;
   logic                 hit_ff, hit_in;

   for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_cmp
      localparam int LO = k / 2;
      localparam int HI = (k / 2 + 1 + k % 2) % AXES;

      assign pair_ok[k] = !(act2_ff[LO] && act2_ff[HI]) || (lhs2[k] <= rhs2[k]);
   end

   assign hit_in = (&axis_ok_ff) && (&pair_ok);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_bus.valid = v3_ff;
   assign rsp_bus.hit   = hit_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sbst_checker.sv
`default_nettype none

module sbst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit
);

   // a held rsp word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("rsp word changed while stalled");

   // a word accepted while rsp keeps draining shows up as a valid rsp word
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted word did not reach rsp in three cycles");

   // an empty output stage never blocks the req side
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output stage");

   // reset empties the pipe
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind segment_box_slab_test sbst_checker u_sbst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_hit   (rsp_bus.hit)
);

`default_nettype wire
